### rtl/tmq_pkg.sv
// Package for the turn marker qualifier: payload types, register map and result codes.
`timescale 1ns / 1ps

package tmq_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CONFIRM_W  = 16;
  localparam int unsigned MINCNT_W   = 3;
  localparam int unsigned CFG_AW     = 5;
  localparam int unsigned CFG_DW     = 32;
  localparam int unsigned MISS_LIMIT_DEF = 3;

  // Register map, in word order.
  typedef enum logic [2:0] {
    REG_DARK_THRESHOLD    = 3'd0,
    REG_GREEN_LOW         = 3'd1,
    REG_GREEN_HIGH        = 3'd2,
    REG_GREEN_PAIR_DIFF   = 3'd3,
    REG_WHITE_LEVEL       = 3'd4,
    REG_CORNER_MIN_COUNT  = 3'd5,
    REG_GREEN_SETTLE_MS   = 3'd6,
    REG_CORNER_CONFIRM_MS = 3'd7
  } reg_idx_t;

  localparam logic [SAMPLE_W-1:0]  DARK_THRESHOLD_RST    = 10'd500;
  localparam logic [SAMPLE_W-1:0]  GREEN_LOW_RST         = 10'd120;
  localparam logic [SAMPLE_W-1:0]  GREEN_HIGH_RST        = 10'd280;
  localparam logic [SAMPLE_W-1:0]  GREEN_PAIR_DIFF_RST   = 10'd80;
  localparam logic [SAMPLE_W-1:0]  WHITE_LEVEL_RST       = 10'd80;
  localparam logic [MINCNT_W-1:0]  CORNER_MIN_COUNT_RST  = 3'd3;
  localparam logic [CONFIRM_W-1:0] GREEN_SETTLE_MS_RST   = 16'd50;
  localparam logic [CONFIRM_W-1:0] CORNER_CONFIRM_MS_RST = 16'd50;

  // Turn directions and reasons as carried in a result beat.
  localparam logic signed [1:0] DIR_NONE  = 2'sb00;
  localparam logic signed [1:0] DIR_LEFT  = 2'sb01;
  localparam logic signed [1:0] DIR_RIGHT = 2'sb11;

  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_GREEN  = 2'd1;
  localparam logic [1:0] CAUSE_CORNER = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SAMPLE_W-1:0] sample_4;
    logic [SAMPLE_W-1:0] sample_5;
    logic [SAMPLE_W-1:0] sample_6;
    logic [SAMPLE_W-1:0] sample_7;
    logic [TIME_W-1:0]   time_ms;
    logic                clear_request;
  } in_item_t;

  typedef struct packed {
    logic signed [1:0] turn_direction;
    logic [1:0]        turn_reason;
    logic              detect_pending;
  } out_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]  dark_threshold;
    logic [SAMPLE_W-1:0]  green_low;
    logic [SAMPLE_W-1:0]  green_high;
    logic [SAMPLE_W-1:0]  green_pair_diff;
    logic [SAMPLE_W-1:0]  white_level;
    logic [MINCNT_W-1:0]  corner_min_count;
    logic [CONFIRM_W-1:0] green_settle_ms;
    logic [CONFIRM_W-1:0] corner_confirm_ms;
  } cfg_t;

  // A pair is green when its floor average lies in the window and the
  // two samples are close to each other.
  function automatic logic pair_green(input logic [SAMPLE_W-1:0] a,
                                      input logic [SAMPLE_W-1:0] b,
                                      input cfg_t cfg);
    logic [SAMPLE_W:0]   sum;
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] diff;
    sum  = {1'b0, a} + {1'b0, b};
    avg  = sum[SAMPLE_W:1];
    diff = (a > b) ? (a - b) : (b - a);
    return (avg >= cfg.green_low) && (avg <= cfg.green_high) &&
           (diff <= cfg.green_pair_diff);
  endfunction

  function automatic logic pair_white(input logic [SAMPLE_W-1:0] a,
                                      input logic [SAMPLE_W-1:0] b,
                                      input cfg_t cfg);
    return (a < cfg.white_level) && (b < cfg.white_level);
  endfunction

endpackage

### rtl/turn_marker_qualifier_core.sv
// Top level of the turn marker qualifier: register file, input stage, detectors, result stage.
`timescale 1ns / 1ps

// Flow: an accepted frame is held and evaluated in the input register, and its result beat is
// registered into out_data once the result register is free. Throughput: one frame per cycle
// while out_ready stays high; the compare logic and detector update fit in a single stage.
// Reset: rst_n is synchronous and active low; it returns every configuration register to its
// default, idles both detectors and empties both pipeline registers.
module turn_marker_qualifier_core
  import tmq_pkg::*;
#(
  parameter int unsigned MISS_LIMIT = MISS_LIMIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // Frame channel.
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  // Result channel.
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CFG_AW-1:0]   paddr,
  input  logic [CFG_DW-1:0]   pwdata,
  output logic [CFG_DW-1:0]   prdata,
  output logic                pready
);

  // The miss counters only need to reach MISS_LIMIT itself.
  localparam int unsigned MissW = $clog2(MISS_LIMIT + 1);
  localparam logic [MissW-1:0] MissLimitC = MissW'(MISS_LIMIT);

  // ---------------------------------------------------------------------------------------------
  // Configuration registers. Writes land in the access phase; reads are purely combinational.
  // ---------------------------------------------------------------------------------------------
  cfg_t     cfg_r;
  reg_idx_t cfg_idx;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_threshold    <= DARK_THRESHOLD_RST;
      cfg_r.green_low         <= GREEN_LOW_RST;
      cfg_r.green_high        <= GREEN_HIGH_RST;
      cfg_r.green_pair_diff   <= GREEN_PAIR_DIFF_RST;
      cfg_r.white_level       <= WHITE_LEVEL_RST;
      cfg_r.corner_min_count  <= CORNER_MIN_COUNT_RST;
      cfg_r.green_settle_ms   <= GREEN_SETTLE_MS_RST;
      cfg_r.corner_confirm_ms <= CORNER_CONFIRM_MS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DARK_THRESHOLD:    cfg_r.dark_threshold    <= pwdata[SAMPLE_W-1:0];
        REG_GREEN_LOW:         cfg_r.green_low         <= pwdata[SAMPLE_W-1:0];
        REG_GREEN_HIGH:        cfg_r.green_high        <= pwdata[SAMPLE_W-1:0];
        REG_GREEN_PAIR_DIFF:   cfg_r.green_pair_diff   <= pwdata[SAMPLE_W-1:0];
        REG_WHITE_LEVEL:       cfg_r.white_level       <= pwdata[SAMPLE_W-1:0];
        REG_CORNER_MIN_COUNT:  cfg_r.corner_min_count  <= pwdata[MINCNT_W-1:0];
        REG_GREEN_SETTLE_MS:   cfg_r.green_settle_ms   <= pwdata[CONFIRM_W-1:0];
        REG_CORNER_CONFIRM_MS: cfg_r.corner_confirm_ms <= pwdata[CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DARK_THRESHOLD:    prdata = CFG_DW'(cfg_r.dark_threshold);
      REG_GREEN_LOW:         prdata = CFG_DW'(cfg_r.green_low);
      REG_GREEN_HIGH:        prdata = CFG_DW'(cfg_r.green_high);
      REG_GREEN_PAIR_DIFF:   prdata = CFG_DW'(cfg_r.green_pair_diff);
      REG_WHITE_LEVEL:       prdata = CFG_DW'(cfg_r.white_level);
      REG_CORNER_MIN_COUNT:  prdata = CFG_DW'(cfg_r.corner_min_count);
      REG_GREEN_SETTLE_MS:   prdata = CFG_DW'(cfg_r.green_settle_ms);
      REG_CORNER_CONFIRM_MS: prdata = CFG_DW'(cfg_r.corner_confirm_ms);
      default:               prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------------------------
  // Pipeline control. The input register holds one frame; it is evaluated and moved into the
  // result register whenever that register is empty or its beat is being taken. The detector
  // state is updated at the same edge, so the next frame always sees the state left by this one.
  // ---------------------------------------------------------------------------------------------
  logic      s1_valid_r;
  in_item_t  s1_r;
  logic      out_valid_r;
  out_item_t out_r;
  out_item_t res_nxt;
  logic      advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Frame features: dark counts per side and the green and white pair tests. Sensors 0..3 form
  // the right side and 4..7 the left side; each side has three adjacent pairs.
  // ---------------------------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] smp [8];
  logic [2:0]          right_dark;
  logic [2:0]          left_dark;
  logic                green_l, green_r, white_l, white_r;
  logic                valid_l, valid_r;
  logic                corner_l, corner_r;

  assign smp[0] = s1_r.sample_0;
  assign smp[1] = s1_r.sample_1;
  assign smp[2] = s1_r.sample_2;
  assign smp[3] = s1_r.sample_3;
  assign smp[4] = s1_r.sample_4;
  assign smp[5] = s1_r.sample_5;
  assign smp[6] = s1_r.sample_6;
  assign smp[7] = s1_r.sample_7;

  always_comb begin
    right_dark = '0;
    left_dark  = '0;
    green_l    = 1'b0;
    green_r    = 1'b0;
    white_l    = 1'b0;
    white_r    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      right_dark = right_dark + 3'(smp[i] > cfg_r.dark_threshold);
      left_dark  = left_dark + 3'(smp[i+4] > cfg_r.dark_threshold);
    end
    for (int i = 0; i < 3; i++) begin
      green_r = green_r | pair_green(smp[i], smp[i+1], cfg_r);
      green_l = green_l | pair_green(smp[i+4], smp[i+5], cfg_r);
      white_r = white_r | pair_white(smp[i], smp[i+1], cfg_r);
      white_l = white_l | pair_white(smp[i+4], smp[i+5], cfg_r);
    end
  end

  // A green marker counts only when it shows on one side and the other side sees white.
  assign valid_l  = green_l && !green_r && white_r;
  assign valid_r  = green_r && !green_l && white_l;
  // A corner needs enough dark sensors on one side and at most one on the other.
  assign corner_l = ({1'b0, left_dark} >= {1'b0, cfg_r.corner_min_count}) && (right_dark <= 3'd1);
  assign corner_r = ({1'b0, right_dark} >= {1'b0, cfg_r.corner_min_count}) && (left_dark <= 3'd1);

  // ---------------------------------------------------------------------------------------------
  // Detector state and its next value.
  // ---------------------------------------------------------------------------------------------
  logic              green_active_r,  green_active_nxt;
  logic [TIME_W-1:0] green_start_r,   green_start_nxt;
  logic              green_left_r,    green_left_nxt;
  logic [MissW-1:0]  green_misses_r,  green_misses_nxt;
  logic              corner_active_r, corner_active_nxt;
  logic [TIME_W-1:0] corner_start_r,  corner_start_nxt;
  logic              corner_left_r,   corner_left_nxt;
  logic [MissW-1:0]  corner_misses_r, corner_misses_nxt;

  logic [TIME_W-1:0] green_elapsed;
  logic [TIME_W-1:0] corner_elapsed;
  logic              green_done;
  logic              corner_done;

  // Elapsed times are taken against the start time after this frame, so a detector that starts
  // now reads zero; the subtraction wraps with the timestamp.
  assign green_elapsed  = s1_r.time_ms - green_start_nxt;
  assign corner_elapsed = s1_r.time_ms - corner_start_nxt;
  assign green_done     = green_elapsed >= TIME_W'(cfg_r.green_settle_ms);
  assign corner_done    = corner_elapsed >= TIME_W'(cfg_r.corner_confirm_ms);

  always_comb begin
    logic [MissW-1:0] g_miss_inc;
    logic [MissW-1:0] c_miss_inc;
    logic             green_emit;
    logic             corner_eval;

    green_active_nxt  = green_active_r;
    green_start_nxt   = green_start_r;
    green_left_nxt    = green_left_r;
    green_misses_nxt  = green_misses_r;
    corner_active_nxt = corner_active_r;
    corner_start_nxt  = corner_start_r;
    corner_left_nxt   = corner_left_r;
    corner_misses_nxt = corner_misses_r;
    g_miss_inc        = green_misses_r + MissW'(1);
    c_miss_inc        = corner_misses_r + MissW'(1);
    green_emit        = 1'b0;
    corner_eval       = 1'b0;

    if (s1_r.clear_request) begin
      // A clear beat idles both detectors and reports nothing.
      green_active_nxt  = 1'b0;
      green_misses_nxt  = '0;
      corner_active_nxt = 1'b0;
      corner_misses_nxt = '0;
    end else if (valid_l || valid_r) begin
      // Green seen: it owns the frame and cancels any corner in progress.
      green_misses_nxt = '0;
      if (!green_active_r) begin
        green_active_nxt = 1'b1;
        green_start_nxt  = s1_r.time_ms;
        green_left_nxt   = valid_l;
      end else if (valid_l != green_left_r) begin
        green_active_nxt = 1'b0;
      end
      corner_active_nxt = 1'b0;
      green_emit        = green_active_nxt;
    end else begin
      corner_eval = 1'b1;
      if (green_active_r) begin
        if (g_miss_inc >= MissLimitC) begin
          green_active_nxt = 1'b0;
          green_misses_nxt = '0;
        end else begin
          green_misses_nxt = g_miss_inc;
          // A still-running green detector that has matured wins over the corner test.
          if (green_done) begin
            green_emit  = 1'b1;
            corner_eval = 1'b0;
          end
        end
      end
      if (corner_eval) begin
        if (corner_l || corner_r) begin
          corner_misses_nxt = '0;
          if (!corner_active_r) begin
            corner_active_nxt = 1'b1;
            corner_start_nxt  = s1_r.time_ms;
            corner_left_nxt   = corner_l;
          end
        end else if (corner_active_r) begin
          if (c_miss_inc >= MissLimitC) begin
            corner_active_nxt = 1'b0;
            corner_misses_nxt = '0;
          end else begin
            corner_misses_nxt = c_miss_inc;
          end
        end
      end
    end

    res_nxt.detect_pending = green_active_nxt || corner_active_nxt;
    if (green_emit && green_done) begin
      res_nxt.turn_direction = green_left_nxt ? DIR_LEFT : DIR_RIGHT;
      res_nxt.turn_reason    = CAUSE_GREEN;
    end else if (corner_eval && corner_active_nxt && corner_done) begin
      res_nxt.turn_direction = corner_left_nxt ? DIR_LEFT : DIR_RIGHT;
      res_nxt.turn_reason    = CAUSE_CORNER;
    end else begin
      res_nxt.turn_direction = DIR_NONE;
      res_nxt.turn_reason    = CAUSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_active_r  <= 1'b0;
      green_start_r   <= '0;
      green_left_r    <= 1'b0;
      green_misses_r  <= '0;
      corner_active_r <= 1'b0;
      corner_start_r  <= '0;
      corner_left_r   <= 1'b0;
      corner_misses_r <= '0;
    end else if (advance) begin
      green_active_r  <= green_active_nxt;
      green_start_r   <= green_start_nxt;
      green_left_r    <= green_left_nxt;
      green_misses_r  <= green_misses_nxt;
      corner_active_r <= corner_active_nxt;
      corner_start_r  <= corner_start_nxt;
      corner_left_r   <= corner_left_nxt;
      corner_misses_r <= corner_misses_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // A beat without a reason never carries a direction.
  a_reason_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.turn_reason == CAUSE_NONE) |-> (out_r.turn_direction == DIR_NONE))
    else $error("result beat has a direction but no reason");

  // Miss counters never reach the limit while stored.
  a_miss_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (green_misses_r < MissLimitC) && (corner_misses_r < MissLimitC))
    else $error("miss counter reached its limit");

  // A clear beat leaves both detectors idle.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_r.clear_request |=> !green_active_r && !corner_active_r)
    else $error("detector still active after clear");

  // The pending flag of a fresh result matches the detector state it left behind.
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_r.detect_pending == (green_active_r || corner_active_r))
    else $error("pending flag disagrees with detector state");
`endif

endmodule

### bench/tb_top.sv
// Self-checking bench for the turn marker qualifier: frame and result handshakes plus APB setup.
`timescale 1ns / 1ps

module tb_top
  import tmq_pkg::*;
();

  // Misses an active detector tolerates before it drops, as built into the block.
  localparam int unsigned MISS_LIMIT = MISS_LIMIT_DEF;
  // Cycles without any beat or bus access before the run is declared hung. A correct beat
  // needs at most a sender gap, the pipeline registers and a receiver stall, so this is far
  // beyond the slowest legal case.
  localparam int unsigned WATCHDOG_CYCLES = 2000;

  // Shapes of frames the stimulus generator can build.
  typedef enum int {
    FK_NOISE,
    FK_GREEN_L,
    FK_GREEN_R,
    FK_GREEN_BOTH,
    FK_CORNER_L,
    FK_CORNER_R,
    FK_WHITE,
    FK_DARK
  } frame_kind_t;

  // The scoreboard keeps its own copy of the registers and of both detectors. Each accepted
  // frame is run through the detectors at once and the turn it must produce is queued; each
  // result beat is checked against the oldest queued turn.
  class turn_checker;
    bit [31:0]  regs [8];
    bit         green_on;
    bit         green_is_left;
    bit [31:0]  green_since;
    bit [3:0]   green_missed;
    bit         corner_on;
    bit         corner_is_left;
    bit [31:0]  corner_since;
    bit [3:0]   corner_missed;
    out_item_t  pending_turns [$];
    int         errors;

    function new();
      regs[REG_DARK_THRESHOLD]    = 32'(DARK_THRESHOLD_RST);
      regs[REG_GREEN_LOW]         = 32'(GREEN_LOW_RST);
      regs[REG_GREEN_HIGH]        = 32'(GREEN_HIGH_RST);
      regs[REG_GREEN_PAIR_DIFF]   = 32'(GREEN_PAIR_DIFF_RST);
      regs[REG_WHITE_LEVEL]       = 32'(WHITE_LEVEL_RST);
      regs[REG_CORNER_MIN_COUNT]  = 32'(CORNER_MIN_COUNT_RST);
      regs[REG_GREEN_SETTLE_MS]   = 32'(GREEN_SETTLE_MS_RST);
      regs[REG_CORNER_CONFIRM_MS] = 32'(CORNER_CONFIRM_MS_RST);
      green_on = 0; green_is_left = 0; green_since = 0; green_missed = 0;
      corner_on = 0; corner_is_left = 0; corner_since = 0; corner_missed = 0;
      errors = 0;
    endfunction

    function bit [31:0] reg_mask(reg_idx_t r);
      case (r)
        REG_CORNER_MIN_COUNT: return 32'h0000_0007;
        REG_GREEN_SETTLE_MS, REG_CORNER_CONFIRM_MS: return 32'h0000_FFFF;
        default: return 32'h0000_03FF;
      endcase
    endfunction

    function void set_reg(reg_idx_t r, bit [31:0] v);
      regs[r] = v & reg_mask(r);
    endfunction

    function void fail(string what);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    function bit is_green(bit [9:0] a, bit [9:0] b);
      bit [10:0] sum;
      bit [9:0]  avg;
      bit [9:0]  diff;
      sum  = {1'b0, a} + {1'b0, b};
      avg  = sum[10:1];
      diff = (a > b) ? a - b : b - a;
      return avg >= regs[REG_GREEN_LOW] && avg <= regs[REG_GREEN_HIGH] &&
             diff <= regs[REG_GREEN_PAIR_DIFF];
    endfunction

    function bit is_white(bit [9:0] a, bit [9:0] b);
      return a < regs[REG_WHITE_LEVEL] && b < regs[REG_WHITE_LEVEL];
    endfunction

    // Pending is sampled from the detector state left behind by this frame.
    function out_item_t turn_result(logic signed [1:0] dir, logic [1:0] why);
      out_item_t r;
      r.turn_direction = dir;
      r.turn_reason    = why;
      r.detect_pending = green_on || corner_on;
      return r;
    endfunction

    function out_item_t qualify_frame(in_item_t f);
      bit [9:0]  s [8];
      bit [31:0] now;
      bit [31:0] elapsed;
      int        left_dark;
      int        right_dark;
      bit        green_l, green_r, white_l, white_r, valid_l, valid_r;
      s[0] = f.sample_0; s[1] = f.sample_1; s[2] = f.sample_2; s[3] = f.sample_3;
      s[4] = f.sample_4; s[5] = f.sample_5; s[6] = f.sample_6; s[7] = f.sample_7;
      now = f.time_ms;
      if (f.clear_request) begin
        green_on = 0; green_missed = 0;
        corner_on = 0; corner_missed = 0;
        return turn_result(DIR_NONE, CAUSE_NONE);
      end
      left_dark = 0; right_dark = 0;
      green_l = 0; green_r = 0; white_l = 0; white_r = 0;
      for (int i = 0; i < 4; i++) begin
        if (s[i] > regs[REG_DARK_THRESHOLD]) right_dark++;
        if (s[i + 4] > regs[REG_DARK_THRESHOLD]) left_dark++;
      end
      for (int i = 0; i < 3; i++) begin
        green_r |= is_green(s[i], s[i + 1]);
        green_l |= is_green(s[i + 4], s[i + 5]);
        white_r |= is_white(s[i], s[i + 1]);
        white_l |= is_white(s[i + 4], s[i + 5]);
      end
      valid_l = green_l && !green_r && white_r;
      valid_r = green_r && !green_l && white_l;

      // A valid green marker owns the frame and idles the corner detector.
      if (valid_l || valid_r) begin
        green_missed = 0;
        if (!green_on) begin
          green_on = 1; green_since = now; green_is_left = valid_l;
        end else if (valid_l != green_is_left) begin
          green_on = 0;
        end
        corner_on = 0;
        elapsed = now - green_since;
        if (green_on && elapsed >= regs[REG_GREEN_SETTLE_MS])
          return turn_result(green_is_left ? DIR_LEFT : DIR_RIGHT, CAUSE_GREEN);
        return turn_result(DIR_NONE, CAUSE_NONE);
      end

      // A green detector that is still running may confirm without corner evaluation.
      if (green_on) begin
        green_missed++;
        elapsed = now - green_since;
        if (green_missed >= MISS_LIMIT) begin
          green_on = 0; green_missed = 0;
        end else if (elapsed >= regs[REG_GREEN_SETTLE_MS]) begin
          return turn_result(green_is_left ? DIR_LEFT : DIR_RIGHT, CAUSE_GREEN);
        end
      end

      if (left_dark >= regs[REG_CORNER_MIN_COUNT] && right_dark <= 1) begin
        corner_missed = 0;
        if (!corner_on) begin
          corner_on = 1; corner_since = now; corner_is_left = 1;
        end
      end else if (right_dark >= regs[REG_CORNER_MIN_COUNT] && left_dark <= 1) begin
        corner_missed = 0;
        if (!corner_on) begin
          corner_on = 1; corner_since = now; corner_is_left = 0;
        end
      end else if (corner_on) begin
        corner_missed++;
        if (corner_missed >= MISS_LIMIT) begin
          corner_on = 0; corner_missed = 0;
        end
      end
      elapsed = now - corner_since;
      if (corner_on && elapsed >= regs[REG_CORNER_CONFIRM_MS])
        return turn_result(corner_is_left ? DIR_LEFT : DIR_RIGHT, CAUSE_CORNER);
      return turn_result(DIR_NONE, CAUSE_NONE);
    endfunction

    function void note_frame(in_item_t f);
      pending_turns.push_back(qualify_frame(f));
    endfunction

    function void check_turn(out_item_t got);
      out_item_t want;
      if (pending_turns.size() == 0) begin
        fail($sformatf("result beat dir %0d reason %0d pending %0d with nothing expected",
                       got.turn_direction, got.turn_reason, got.detect_pending));
        return;
      end
      want = pending_turns.pop_front();
      if (got.turn_direction !== want.turn_direction || got.turn_reason !== want.turn_reason ||
          got.detect_pending !== want.detect_pending)
        fail($sformatf("dir exp %0d got %0d, reason exp %0d got %0d, pending exp %0d got %0d",
                       want.turn_direction, got.turn_direction, want.turn_reason,
                       got.turn_reason, want.detect_pending, got.detect_pending));
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [CFG_AW-1:0]   paddr     = '0;
  logic [CFG_DW-1:0]   pwdata    = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  turn_checker board = new();
  // When set, the frame sender runs without gaps for the current stretch of frames.
  bit          sender_fast = 1'b0;
  int unsigned quiet_cycles = 0;

  turn_marker_qualifier_core #(
    .MISS_LIMIT (MISS_LIMIT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: any frame beat, result beat or bus access counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) === 1'b1 || (out_valid && out_ready) === 1'b1 || psel) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_CYCLES) begin
          $display("FAIL turn_marker_qualifier_core");
          $finish;
        end
      end
    end
  end

  // Uniform value in [lo, hi], clipped to the legal sample range. An empty range falls back
  // to its upper end, which is what keeps a generator from forcing an impossible class.
  function automatic bit [9:0] pick(int lo, int hi);
    if (hi > 1000) hi = 1000;
    if (hi < 0) return 10'd0;
    if (lo < 0) lo = 0;
    if (lo > hi) return hi[9:0];
    return 10'($urandom_range(hi, lo));
  endfunction

  // Builds one frame of the given shape against the thresholds currently programmed, so that
  // green pairs, white pairs and dark counts actually land where the detectors look.
  function automatic in_item_t make_frame(frame_kind_t kind, bit [31:0] now, bit clr);
    bit [9:0] s [8];
    int       dt, wt, glo, ghi, gd, cm;
    int       side, other, p, n, rot, idx;
    in_item_t f;
    dt  = board.regs[REG_DARK_THRESHOLD];
    glo = board.regs[REG_GREEN_LOW];
    ghi = board.regs[REG_GREEN_HIGH];
    gd  = board.regs[REG_GREEN_PAIR_DIFF];
    wt  = board.regs[REG_WHITE_LEVEL];
    cm  = board.regs[REG_CORNER_MIN_COUNT];
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 15))
        0: s[i] = 10'd0;
        1: s[i] = 10'd1000;
        default: s[i] = pick(0, 1000);
      endcase
    end
    case (kind)
      FK_GREEN_L, FK_GREEN_R, FK_GREEN_BOTH: begin
        side  = (kind == FK_GREEN_R) ? 0 : 4;
        other = 4 - side;
        p = side + $urandom_range(0, 2);
        s[p]     = pick(glo, ghi);
        s[p + 1] = pick(int'(s[p]), int'(s[p]) + (gd > 2 ? 2 : gd));
        p = other + $urandom_range(0, 2);
        if (kind == FK_GREEN_BOTH) begin
          s[p]     = pick(glo, ghi);
          s[p + 1] = s[p];
        end else begin
          s[p]     = pick(0, wt - 1);
          s[p + 1] = pick(0, wt - 1);
        end
      end
      FK_CORNER_L, FK_CORNER_R: begin
        side  = (kind == FK_CORNER_L) ? 4 : 0;
        other = 4 - side;
        n   = $urandom_range(cm > 4 ? 4 : cm, 4);
        rot = $urandom_range(0, 3);
        for (int i = 0; i < 4; i++) begin
          idx = side + (i + rot) % 4;
          s[idx] = (i < n) ? pick(dt + 1, 1000) : pick(0, dt);
          s[other + i] = pick(0, dt);
        end
        if ($urandom_range(0, 1)) s[other + $urandom_range(0, 3)] = pick(dt + 1, 1000);
      end
      FK_WHITE: for (int i = 0; i < 8; i++) s[i] = pick(0, wt - 1);
      FK_DARK:  for (int i = 0; i < 8; i++) s[i] = pick(dt + 1, 1000);
      default: ;
    endcase
    f.sample_0 = s[0]; f.sample_1 = s[1]; f.sample_2 = s[2]; f.sample_3 = s[3];
    f.sample_4 = s[4]; f.sample_5 = s[5]; f.sample_6 = s[6]; f.sample_7 = s[7];
    f.time_ms = now;
    f.clear_request = clr;
    return f;
  endfunction

  // Presents one frame after a random gap and holds it until the block takes it. With no gap
  // valid simply stays high into the next beat.
  task automatic drive_frame(in_item_t f);
    int gap;
    gap = sender_fast ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_ready !== 1'b1);
    board.note_frame(f);
  endtask

  // Lets every outstanding result drain, then allows for the two-stage pipeline to settle.
  task automatic wait_drain();
    do @(posedge clk); while (board.pending_turns.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // One APB write followed by a read of the same register. The read must return the value as
  // held within the register's width, whatever was sent in the upper bits.
  task automatic cfg_write(reg_idx_t r, bit [31:0] v, bit junk);
    if (junk) v = v | ($urandom & ~board.reg_mask(r));
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    board.set_reg(r, v);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== board.regs[r])
      board.fail($sformatf("register %s reads %h, expected %h", r.name(), prdata,
                           board.regs[r]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(int dt, int glo, int ghi, int gd, int wt, int cm, int gc,
                                int cc, bit junk);
    cfg_write(REG_DARK_THRESHOLD, dt, junk);
    cfg_write(REG_GREEN_LOW, glo, junk);
    cfg_write(REG_GREEN_HIGH, ghi, junk);
    cfg_write(REG_GREEN_PAIR_DIFF, gd, junk);
    cfg_write(REG_WHITE_LEVEL, wt, junk);
    cfg_write(REG_CORNER_MIN_COUNT, cm, junk);
    cfg_write(REG_GREEN_SETTLE_MS, gc, junk);
    cfg_write(REG_CORNER_CONFIRM_MS, cc, junk);
  endtask

  // Random traffic built from episodes: a run of frames of one shape with small time steps,
  // so that detectors start, miss, recover and confirm. Stray noise frames act as misses,
  // and occasional clears and time jumps break the episodes up.
  task automatic run_phase(int count, bit [31:0] t0, bit hold_mid);
    int          done, len, roll;
    frame_kind_t kind;
    bit [31:0]   now;
    bit          clr;
    now  = t0;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 22)      kind = FK_GREEN_L;
      else if (roll < 44) kind = FK_GREEN_R;
      else if (roll < 62) kind = FK_CORNER_L;
      else if (roll < 80) kind = FK_CORNER_R;
      else if (roll < 86) kind = FK_GREEN_BOTH;
      else if (roll < 90) kind = FK_WHITE;
      else if (roll < 93) kind = FK_DARK;
      else                kind = FK_NOISE;
      len = $urandom_range(1, 14);
      sender_fast = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < len && done < count; j++) begin
        case ($urandom_range(0, 49))
          0: now = $urandom;
          1: now = now + $urandom_range(0, 70000);
          default: now = now + $urandom_range(0, 25);
        endcase
        clr = ($urandom_range(0, 59) == 0);
        drive_frame(make_frame($urandom_range(0, 6) == 0 ? FK_NOISE : kind, now, clr));
        done++;
        // Hold the sender back once until the block has nothing left in flight.
        if (hold_mid && done == count / 2) begin
          in_valid <= 1'b0;
          wait_drain();
        end
      end
    end
    in_valid <= 1'b0;
    wait_drain();
  endtask

  // Directed opening at the reset settings: 500 dark, green 120..280, confirm after 50 ms.
  task automatic run_directed();
    bit [31:0] t;
    in_item_t  f;
    t = 32'd1000;
    f = '0;
    f.time_ms = t;
    drive_frame(f);                                   // all samples at the low extreme
    f.sample_0 = 10'd1000; f.sample_1 = 10'd1000; f.sample_2 = 10'd1000;
    f.sample_3 = 10'd1000; f.sample_4 = 10'd1000; f.sample_5 = 10'd1000;
    f.sample_6 = 10'd1000; f.sample_7 = 10'd1000;
    drive_frame(f);                                   // all samples at the high extreme
    // A left marker held for 50 ms confirms on its sixth frame.
    repeat (6) begin
      t = t + 10;
      drive_frame(make_frame(FK_GREEN_L, t, 1'b0));
    end
    // Two misses keep the confirmed marker; the third one drops it.
    repeat (3) begin
      t = t + 10;
      drive_frame(make_frame(FK_WHITE, t, 1'b0));
    end
    // A right marker followed by a left one turns the detector off.
    t = t + 10;
    drive_frame(make_frame(FK_GREEN_R, t, 1'b0));
    t = t + 10;
    drive_frame(make_frame(FK_GREEN_L, t, 1'b0));
    // Green on both sides is not a marker.
    t = t + 10;
    drive_frame(make_frame(FK_GREEN_BOTH, t, 1'b0));
    // A right corner held long enough to confirm, then a miss and a clear.
    repeat (6) begin
      t = t + 10;
      drive_frame(make_frame(FK_CORNER_R, t, 1'b0));
    end
    t = t + 10;
    drive_frame(make_frame(FK_WHITE, t, 1'b0));
    t = t + 10;
    drive_frame(make_frame(FK_CORNER_R, t, 1'b1));
    // A left corner across the wrap of the millisecond counter.
    t = 32'hFFFF_FFE0;
    repeat (3) begin
      t = t + 30;
      drive_frame(make_frame(FK_CORNER_L, t, 1'b0));
    end
    in_valid <= 1'b0;
    wait_drain();
  endtask

  // Result sink: random stalls, with stretches where it is always ready.
  initial begin : result_sink
    int stall;
    int beats;
    bit rx_fast;
    beats   = 0;
    rx_fast = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (beats % 25 == 0) rx_fast = ($urandom_range(0, 3) == 0);
      stall = rx_fast ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      board.check_turn(out_data);
      beats++;
    end
  end

  // Main sequence: reset, directed frames at the defaults, then phases of random traffic
  // under a series of settings. Registers are only written once the block has drained.
  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_phase(200, $urandom, 1'b1);

    apply_settings(500, 120, 280, 80, 80, 3, 20, 30, 1'b0);
    run_phase(220, 32'hFFFF_FF00, 1'b0);

    // Low extremes: everything nonzero is dark, nothing is white, a corner needs no dark
    // samples and any detector confirms on its first frame.
    apply_settings(0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
    run_phase(150, $urandom, 1'b0);

    // High extremes, with every spare write bit set at random.
    apply_settings(1023, 1023, 1023, 1023, 1023, 7, 65535, 65535, 1'b1);
    run_phase(150, $urandom, 1'b0);

    apply_settings(1000, 0, 1000, 1000, 1000, 1, 100, 0, 1'b0);
    run_phase(150, $urandom, 1'b0);

    repeat (5) begin
      int glo;
      glo = $urandom_range(0, 400);
      apply_settings($urandom_range(100, 900), glo, glo + $urandom_range(0, 300),
                     $urandom_range(0, 200), $urandom_range(0, 300), $urandom_range(1, 4),
                     $urandom_range(0, 200), $urandom_range(0, 200), $urandom_range(0, 1));
      run_phase(200, $urandom, 1'b0);
    end

    // Give a stray extra beat time to show up before judging.
    repeat (6) @(posedge clk);
    if (board.pending_turns.size() != 0)
      board.fail($sformatf("%0d expected results never arrived", board.pending_turns.size()));
    if (board.errors == 0)
      $display("PASS turn_marker_qualifier_core");
    else
      $display("FAIL turn_marker_qualifier_core");
    $finish;
  end

endmodule
